>>> rtl/adc_button_ladder_debouncer_defines.svh
// ----------------------------------------------------------------------------
// adc button ladder debouncer assertion macros
// shared property wrappers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ADC_BUTTON_LADDER_DEBOUNCER_DEFINES_SVH
`define ADC_BUTTON_LADDER_DEBOUNCER_DEFINES_SVH

// condition implies consequence in the same cycle
`define ABLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define ABLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/abld_pkg.sv
// ----------------------------------------------------------------------------
// abld_pkg
// key and status codes, register indexes and the configuration bundle
// ----------------------------------------------------------------------------
`default_nettype none

package abld_pkg;

    // key codes
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_B1     = 3'd1;
    localparam logic [2:0] KEY_B2     = 3'd2;
    localparam logic [2:0] KEY_AMB    = 3'd3;
    localparam logic [2:0] KEY_UNSAFE = 3'd4;

    // status codes
    localparam logic [1:0] ST_SAME    = 2'd0;
    localparam logic [1:0] ST_CHANGED = 2'd1;
    localparam logic [1:0] ST_UNSAFE  = 2'd2;
    localparam logic [1:0] ST_EARLY   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_NONE_WIN  = 3'd0;
    localparam logic [2:0] REG_B1_WIN    = 3'd1;
    localparam logic [2:0] REG_B2_WIN    = 3'd2;
    localparam logic [2:0] REG_BOTH_WIN  = 3'd3;
    localparam logic [2:0] REG_ADC_LIMIT = 3'd4;
    localparam logic [2:0] REG_STABLE    = 3'd5;
    localparam logic [2:0] REG_PERIOD    = 3'd6;
    localparam logic [2:0] REG_LATENESS  = 3'd7;

    // configuration register bundle
    typedef struct packed {
        logic [31:0] none_window;
        logic [31:0] button1_window;
        logic [31:0] button2_window;
        logic [31:0] both_window;
        logic [15:0] adc_limit;
        logic [15:0] stable_count;
        logic [15:0] period_ms;
        logic [15:0] lateness_ms;
    } t_cfg;

    // inclusive window match, min in the low half, max in the high half
    function automatic logic in_window(input logic [31:0] win, input logic [15:0] code);
        return (code >= win[15:0]) && (code <= win[31:16]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/abld_ifs.sv
// ----------------------------------------------------------------------------
// abld channel interfaces
// sample, result and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface abld_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [15:0] adc_code;

    modport source (output valid, output now_ms, output adc_code, input ready);
    modport sink   (input valid, input now_ms, input adc_code, output ready);
endinterface

interface abld_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] key;

    modport source (output valid, output status, output key, input ready);
    modport sink   (input valid, input status, input key, output ready);
endinterface

interface abld_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/abld_cfg.sv
// ----------------------------------------------------------------------------
// abld_cfg
// configuration register file, written over its own valid/ready channel
// ----------------------------------------------------------------------------
`default_nettype none

module abld_cfg
    import abld_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    abld_cfg_if.sink     i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;

    // always ready, a write lands in the next cycle
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.none_window    <= '0;
            r_cfg.button1_window <= '0;
            r_cfg.button2_window <= '0;
            r_cfg.both_window    <= '0;
            r_cfg.adc_limit      <= 16'd4095;
            r_cfg.stable_count   <= 16'd3;
            r_cfg.period_ms      <= 16'd10;
            r_cfg.lateness_ms    <= 16'd10;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_NONE_WIN:  r_cfg.none_window    <= i_cfg.data;
                REG_B1_WIN:    r_cfg.button1_window <= i_cfg.data;
                REG_B2_WIN:    r_cfg.button2_window <= i_cfg.data;
                REG_BOTH_WIN:  r_cfg.both_window    <= i_cfg.data;
                REG_ADC_LIMIT: r_cfg.adc_limit      <= i_cfg.data[15:0];
                REG_STABLE:    r_cfg.stable_count   <= i_cfg.data[15:0];
                REG_PERIOD:    r_cfg.period_ms      <= i_cfg.data[15:0];
                REG_LATENESS:  r_cfg.lateness_ms    <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/abld_classify.sv
// ----------------------------------------------------------------------------
// abld_classify
// maps one adc code to a key class through the limit and four windows
// ----------------------------------------------------------------------------
`default_nettype none

module abld_classify
    import abld_pkg::*;
(
    input  t_cfg        i_cfg,
    input  wire [15:0]  i_adc_code,
    output logic [2:0]  o_measured
);

    // first matching window wins: none, button1, button2, both
    always_comb begin
        if (i_adc_code > i_cfg.adc_limit) begin
            o_measured = KEY_UNSAFE;
        end else if (in_window(i_cfg.none_window, i_adc_code)) begin
            o_measured = KEY_NONE;
        end else if (in_window(i_cfg.button1_window, i_adc_code)) begin
            o_measured = KEY_B1;
        end else if (in_window(i_cfg.button2_window, i_adc_code)) begin
            o_measured = KEY_B2;
        end else if (in_window(i_cfg.both_window, i_adc_code)) begin
            o_measured = KEY_AMB;
        end else begin
            o_measured = KEY_UNSAFE;
        end
    end

endmodule

`default_nettype wire

>>> rtl/abld_core.sv
// ----------------------------------------------------------------------------
// abld_core
// cadence check, quarantine and debounce state, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "adc_button_ladder_debouncer_defines.svh"

module abld_core
    import abld_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  t_cfg           i_cfg,
    input  wire            i_valid,
    input  wire [31:0]     i_now_ms,
    input  wire [2:0]      i_measured,
    output logic           o_advance,
    abld_result_if.source  o_result
);

    logic        r_have_time, n_have_time;
    logic [31:0] r_baseline,  n_baseline;
    logic [2:0]  r_pub,       n_pub;
    logic [2:0]  r_cand,      n_cand;
    logic [15:0] r_run,       n_run;
    logic        r_quar,      n_quar;
    logic        r_out_valid;
    logic [1:0]  r_status,    n_status;
    logic [2:0]  r_key;

    logic [31:0] elapsed;
    logic [16:0] window_end;
    logic        early;
    logic        late;
    logic        swap;
    logic [15:0] run_next;
    logic        run_hit;

    // step when the result slot is free or being drained
    assign o_advance = i_valid && (!r_out_valid || o_result.ready);

    // cadence and run arithmetic
    assign elapsed    = i_now_ms - r_baseline;
    assign window_end = {1'b0, i_cfg.period_ms} + {1'b0, i_cfg.lateness_ms};
    assign early      = r_have_time && (elapsed < {16'd0, i_cfg.period_ms});
    assign late       = r_have_time && (elapsed > {15'd0, window_end});
    assign swap       = ((r_pub == KEY_B1) && (i_measured == KEY_B2)) ||
                        ((r_pub == KEY_B2) && (i_measured == KEY_B1));
    assign run_next   = (r_cand == i_measured) ? (r_run + 16'd1) : 16'd1;
    assign run_hit    = run_next >= i_cfg.stable_count;

    // next state for one sample
    always_comb begin
        n_have_time = r_have_time;
        n_baseline  = r_baseline;
        n_pub       = r_pub;
        n_cand      = r_cand;
        n_run       = r_run;
        n_quar      = r_quar;
        n_status    = ST_SAME;
        if (early) begin
            n_status = ST_EARLY;
        end else if (late || (i_measured == KEY_UNSAFE)) begin
            n_have_time = 1'b1;
            n_baseline  = i_now_ms;
            n_cand      = KEY_UNSAFE;
            n_run       = '0;
            n_pub       = KEY_UNSAFE;
            n_quar      = 1'b1;
            n_status    = ST_UNSAFE;
        end else begin
            n_have_time = 1'b1;
            n_baseline  = i_now_ms;
            if ((i_measured == KEY_AMB) || (!r_quar && swap)) begin
                // ambiguous or direct swap enters quarantine
                n_cand   = KEY_UNSAFE;
                n_run    = '0;
                n_quar   = 1'b1;
                n_pub    = KEY_AMB;
                n_status = (r_pub != KEY_AMB) ? ST_CHANGED : ST_SAME;
            end else if (r_quar) begin
                if (i_measured != KEY_NONE) begin
                    n_cand   = KEY_UNSAFE;
                    n_run    = '0;
                    n_pub    = KEY_UNSAFE;
                    n_status = (r_pub != KEY_UNSAFE) ? ST_CHANGED : ST_SAME;
                end else if (run_hit) begin
                    // stable release to none
                    n_cand   = KEY_UNSAFE;
                    n_run    = '0;
                    n_quar   = 1'b0;
                    n_pub    = KEY_NONE;
                    n_status = (r_pub != KEY_NONE) ? ST_CHANGED : ST_SAME;
                end else begin
                    n_cand = KEY_NONE;
                    n_run  = run_next;
                end
            end else if (i_measured == r_pub) begin
                n_cand = KEY_UNSAFE;
                n_run  = '0;
            end else if (run_hit) begin
                n_cand   = KEY_UNSAFE;
                n_run    = '0;
                n_pub    = i_measured;
                n_status = ST_CHANGED;
            end else begin
                n_cand = i_measured;
                n_run  = run_next;
            end
        end
    end

    // debounce state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_time <= 1'b0;
            r_baseline  <= '0;
            r_pub       <= KEY_UNSAFE;
            r_cand      <= KEY_UNSAFE;
            r_run       <= '0;
            r_quar      <= 1'b1;
        end else if (o_advance) begin
            r_have_time <= n_have_time;
            r_baseline  <= n_baseline;
            r_pub       <= n_pub;
            r_cand      <= n_cand;
            r_run       <= n_run;
            r_quar      <= n_quar;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_status <= n_status;
            r_key    <= n_pub;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.status = r_status;
    assign o_result.key    = r_key;

    // checks
    `ABLD_ASSERT_NOW(a_unsafe_key, r_out_valid && (r_status == ST_UNSAFE), r_key == KEY_UNSAFE, "unsafe status without unsafe key")
    `ABLD_ASSERT_NEXT(a_early_holds, o_advance && early, $stable(r_pub) && $stable(r_baseline), "early sample changed state")
    `ABLD_ASSERT_NEXT(a_release_none, o_advance && r_quar && !n_quar, r_pub == KEY_NONE, "quarantine left without publishing none")
    `ABLD_ASSERT_NOW(a_cand_clear, r_cand == KEY_UNSAFE, r_run == 16'd0, "cleared candidate with nonzero run")

endmodule

`default_nettype wire

>>> rtl/adc_button_ladder_debouncer.sv
// ----------------------------------------------------------------------------
// adc_button_ladder_debouncer
// two-button resistor ladder debouncer with cadence check and quarantine
// ----------------------------------------------------------------------------
// Takes one timestamped sample per cycle and returns one result per sample:
// the sample is captured in an input register, classified and stepped through
// the debounce state, and the status and key land in a result register. Both
// registers move together so a new sample is accepted every cycle while the
// result side keeps up; ready drops only when both registers hold work and the
// result is stalled. Configuration writes take effect in the cycle after the
// write and are meant to be made while no sample is in flight.
`default_nettype none

module adc_button_ladder_debouncer
    import abld_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    abld_cfg_if.sink       i_cfg,
    abld_sample_if.sink    i_sample,
    abld_result_if.source  o_result
);

    t_cfg        cfg;
    logic        r_in_valid;
    logic [31:0] r_now_ms;
    logic [15:0] r_adc_code;
    logic [2:0]  measured;
    logic        advance;

    // input register accepts when empty or handing over this cycle
    assign i_sample.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_now_ms   <= i_sample.now_ms;
            r_adc_code <= i_sample.adc_code;
        end
    end

    // configuration registers
    abld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // window classification
    abld_classify u_classify (
        .i_cfg      (cfg),
        .i_adc_code (r_adc_code),
        .o_measured (measured)
    );

    // debounce state and result register
    abld_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (r_in_valid),
        .i_now_ms   (r_now_ms),
        .i_measured (measured),
        .o_advance  (advance),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
